// ===== rtl/far_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and constants for the fraction arithmetic and reduction core.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int RES_BITS     = 33;
  localparam int CNT_BITS     = $clog2(SUM_BITS + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_DIVD_START,
    ST_DIVD_WAIT,
    ST_DONE
  } state_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/far_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// far_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module far_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire far_pkg::div_ctrl_t            ctrl,
  input  wire logic [far_pkg::SUM_BITS-1:0]  dividend,
  input  wire logic [far_pkg::SUM_BITS-1:0]  divisor,
  output far_pkg::div_stat_t                 stat,
  output logic      [far_pkg::SUM_BITS-1:0]  quotient,
  output logic      [far_pkg::SUM_BITS-1:0]  remainder
);
  import far_pkg::*;

  logic [SUM_BITS-1:0] dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [SUM_BITS:0]   trial;
  logic [SUM_BITS:0]   shifted;

  assign shifted = {remainder, quotient[SUM_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy      <= 1'b1;
        cnt       <= CNT_BITS'(SUM_BITS);
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial[SUM_BITS]) begin
          remainder <= shifted[SUM_BITS-1:0];
          quotient  <= {quotient[SUM_BITS-2:0], 1'b0};
        end else begin
          remainder <= trial[SUM_BITS-1:0];
          quotient  <= {quotient[SUM_BITS-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ===== rtl/fraction_arith_reduce_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_arith_reduce_core
// Adds, subtracts, multiplies or divides two fractions and reduces by gcd.
// ----------------------------------------------------------------------------
// Channel | Direction | Fields
// in      | input     | req_type, a_num, a_den, b_num, b_den
// out     | output    | res_num, res_den, zero_den
//
// There is one divider pass per Euclid step of the gcd, then one each for the
// numerator and the denominator, all on the one shared shift-subtract divider.
// Reset is synchronous and clears the sequencer state and out_valid.
// in_stall is high whenever an item is in work; out_stall holds the result.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           req_type,
  input  wire logic signed [far_pkg::OPERAND_BITS-1:0] a_num,
  input  wire logic signed [far_pkg::OPERAND_BITS-1:0] a_den,
  input  wire logic signed [far_pkg::OPERAND_BITS-1:0] b_num,
  input  wire logic signed [far_pkg::OPERAND_BITS-1:0] b_den,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [far_pkg::RES_BITS-1:0]       res_num,
  output logic signed [far_pkg::RES_BITS-1:0]       res_den,
  output logic                                      zero_den
);
  import far_pkg::*;

  state_t state, state_next;
  op_t    op;
  logic signed [OPERAND_BITS-1:0] an, ad, bn, bd;
  logic signed [PROD_BITS-1:0]    p1, p2, prod;
  logic signed [SUM_BITS-1:0]     num, den;
  logic [SUM_BITS-1:0] gx, gy, gcd_val, nq;
  logic                num_neg, den_neg;

  div_ctrl_t           dctrl;
  div_stat_t           dstat;
  logic [SUM_BITS-1:0] d_dividend, d_divisor, d_quot, d_rem;

  logic [SUM_BITS-1:0] nm, dm;
  logic signed [OPERAND_BITS-1:0] m1a, m1b;

  assign nm = num[SUM_BITS-1] ? SUM_BITS'(-num) : num;
  assign dm = den[SUM_BITS-1] ? SUM_BITS'(-den) : den;

  far_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctrl), .dividend(d_dividend),
    .divisor(d_divisor), .stat(dstat), .quotient(d_quot), .remainder(d_rem)
  );

  // One multiplier, used in turn for each cross product.
  always_comb begin
    m1a = ad;
    m1b = bd;
    case (state)
      ST_MUL1: if (op == OP_DIV) begin
        m1a = ad;
        m1b = bn;
      end
      ST_MUL2: begin
        m1a = an;
        m1b = (op == OP_MUL) ? bn : bd;
      end
      ST_COMB: begin
        m1a = bn;
        m1b = ad;
      end
      default: ;
    endcase
  end

  assign prod = m1a * m1b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        op <= op_t'(req_type);
        an <= a_num; ad <= a_den; bn <= b_num; bd <= b_den;
      end
      ST_MUL1: p1 <= prod;
      ST_MUL2: p2 <= prod;
      ST_COMB: begin
        den <= {p1[PROD_BITS-1], p1};
        if (op == OP_ADD) num <= {p2[PROD_BITS-1], p2} + {prod[PROD_BITS-1], prod};
        else if (op == OP_SUB) num <= {p2[PROD_BITS-1], p2} - {prod[PROD_BITS-1], prod};
        else num <= {p2[PROD_BITS-1], p2};
      end
      ST_GCD_START: begin
        num_neg <= num[SUM_BITS-1];
        den_neg <= den[SUM_BITS-1];
        gx <= nm;
        gy <= dm;
      end
      ST_GCD_WAIT: if (dstat.done) begin
        gx <= gy;
        gy <= d_rem;
      end
      ST_DIVN_START: begin
        if (gx == '0 || nm == '0) gcd_val <= SUM_BITS'(1);
        else gcd_val <= gx;
      end
      ST_DIVN_WAIT: if (dstat.done) nq <= d_quot;
      ST_DIVD_WAIT: if (dstat.done) begin
        res_num  <= RES_BITS'(num_neg ? -nq : nq);
        res_den  <= RES_BITS'(den_neg ? -d_quot : d_quot);
        zero_den <= (d_quot == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE) || out_valid;
    dctrl.start = 1'b0;
    d_dividend = gx;
    d_divisor  = gy;
    unique case (state)
      ST_IDLE:      if (in_valid && !in_stall) state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_COMB;
      ST_COMB:      state_next = ST_GCD_START;
      ST_GCD_START: state_next = ST_GCD_WAIT;
      ST_GCD_WAIT: begin
        if (gy == '0 || nm == '0) state_next = ST_DIVN_START;
        else if (dstat.done) state_next = ST_GCD_WAIT;
        else dctrl.start = !dstat.busy;
      end
      ST_DIVN_START: state_next = ST_DIVN_WAIT;
      ST_DIVN_WAIT: begin
        d_dividend = nm;
        d_divisor  = gcd_val;
        dctrl.start = !dstat.busy && !dstat.done;
        if (dstat.done) state_next = ST_DIVD_START;
      end
      ST_DIVD_START: state_next = ST_DIVD_WAIT;
      ST_DIVD_WAIT: begin
        d_dividend = dm;
        d_divisor  = gcd_val;
        dctrl.start = !dstat.busy && !dstat.done;
        if (dstat.done) state_next = ST_DONE;
      end
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_den == (res_den == '0))) else $error("zero_den mismatch");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    dctrl.start |-> !dstat.busy) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire
